/* rtl/sht_pkg.sv */
// ============================================================================
// sht_pkg: shared types and codes of the sorted handle table
// Operation codes, result status codes, the command kinds that the front
// end passes to the engine, and the command type carried through the queue.
// ============================================================================
`default_nettype none

package sht_pkg;

    localparam int unsigned OP_WIDTH     = 2;
    localparam int unsigned ST_WIDTH     = 2;
    localparam int unsigned FIELD_WIDTH  = 64;
    localparam int unsigned COUNT_OUT_W  = 5;
    localparam int unsigned KIND_WIDTH   = 3;

    localparam logic [OP_WIDTH-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_FIND   = 2'd2;

    localparam logic [ST_WIDTH-1:0] ST_OK        = 2'd0;
    localparam logic [ST_WIDTH-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_WIDTH-1:0] ST_FULL      = 2'd2;

    localparam logic [KIND_WIDTH-1:0] KIND_INSERT    = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_REMOVE    = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_FIND      = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_DONE_OK   = 3'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_DONE_MISS = 3'd4;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = 1;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]  kind;
        logic [FIELD_WIDTH-1:0] key;
        logic [FIELD_WIDTH-1:0] entry_ref;
    } t_cmd;

endpackage

`default_nettype wire

/* rtl/sht_front.sv */
// ============================================================================
// sht_front: input acceptance, classification and command queue
// Classifies each incoming transaction into a command kind and holds it in a
// two-entry queue until the engine takes it.
// ============================================================================
`default_nettype none

module sht_front
    import sht_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [OP_WIDTH-1:0]    i_op,
    input  wire logic [FIELD_WIDTH-1:0] i_key,
    input  wire logic [FIELD_WIDTH-1:0] i_entry_ref,
    output logic                        o_cmd_valid,
    input  wire logic                   i_cmd_ready,
    output t_cmd                        o_cmd
);

    t_cmd                r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_fill;
    t_cmd                w_cmd;
    logic                w_push;
    logic                w_pop;

    always_comb begin
        w_cmd.key       = i_key;
        w_cmd.entry_ref = i_entry_ref;
        case (i_op)
            OP_INSERT: begin
                w_cmd.kind = (i_entry_ref == '0) ? KIND_DONE_OK : KIND_INSERT;
            end
            OP_REMOVE: begin
                w_cmd.kind = (i_entry_ref == '0) ? KIND_DONE_MISS : KIND_REMOVE;
            end
            OP_FIND: begin
                w_cmd.kind = KIND_FIND;
            end
            default: begin
                w_cmd.kind = KIND_DONE_MISS;
            end
        endcase
    end

    assign o_in_ready  = (r_fill != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_queue[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + (QUEUE_AW + 1)'(1);
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - (QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/sht_engine.sv */
// ============================================================================
// sht_engine: table storage and operation sequencer
// Holds the sorted key and reference memories and carries out insert,
// remove and binary search with at most one memory access per cycle, then
// registers the result transaction.
// ============================================================================
`default_nettype none

module sht_engine
    import sht_pkg::*;
#(
    parameter int unsigned DEPTH     = 16,
    parameter int unsigned KEY_WIDTH = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cmd_valid,
    output logic                        o_cmd_ready,
    input  wire t_cmd                   i_cmd,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [ST_WIDTH-1:0]         o_status,
    output logic [FIELD_WIDTH-1:0]      o_found_ref,
    output logic [COUNT_OUT_W-1:0]      o_entry_count
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS     = 4'd1;
    localparam logic [3:0] S_INS_CMP = 4'd2;
    localparam logic [3:0] S_REM_RD  = 4'd3;
    localparam logic [3:0] S_REM_CMP = 4'd4;
    localparam logic [3:0] S_SH_RD   = 4'd5;
    localparam logic [3:0] S_SH_WR   = 4'd6;
    localparam logic [3:0] S_FND_RD  = 4'd7;
    localparam logic [3:0] S_FND_CMP = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [KEY_WIDTH-1:0]   mem_key [DEPTH];
    logic [FIELD_WIDTH-1:0] mem_ref [DEPTH];

    logic [3:0]             r_state,  n_state;
    logic [CW-1:0]          r_count,  n_count;
    logic [CW-1:0]          r_idx,    n_idx;
    logic [CW-1:0]          r_lo,     n_lo;
    logic [CW-1:0]          r_hi1,    n_hi1;
    logic [KEY_WIDTH-1:0]   r_key,    n_key;
    logic [FIELD_WIDTH-1:0] r_ref,    n_ref;
    logic [ST_WIDTH-1:0]    r_status, n_status;
    logic [FIELD_WIDTH-1:0] r_found,  n_found;
    logic [KEY_WIDTH-1:0]   r_rd_key;
    logic [FIELD_WIDTH-1:0] r_rd_ref;
    logic                   r_out_valid;
    logic [ST_WIDTH-1:0]    r_out_status;
    logic [FIELD_WIDTH-1:0] r_out_found;
    logic [COUNT_OUT_W-1:0] r_out_count;

    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [KEY_WIDTH-1:0]   w_wkey;
    logic [FIELD_WIDTH-1:0] w_wref;
    logic                   w_re;
    logic [AW-1:0]          w_raddr;
    logic                   w_load;
    logic [CW-1:0]          w_idx_inc;
    logic [CW-1:0]          w_idx_dec;
    logic [CW:0]            w_mid_sum;
    logic [CW-1:0]          w_mid;
    logic [CW+COUNT_OUT_W-1:0] w_count_ext;

    assign w_idx_inc   = r_idx + CW'(1);
    assign w_idx_dec   = r_idx - CW'(1);
    assign w_mid_sum   = {1'b0, r_lo} + {1'b0, r_hi1} - (CW + 1)'(1);
    assign w_mid       = w_mid_sum[CW:1];
    assign w_count_ext = {{COUNT_OUT_W{1'b0}}, r_count};
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_lo        = r_lo;
        n_hi1       = r_hi1;
        n_key       = r_key;
        n_ref       = r_ref;
        n_status    = r_status;
        n_found     = r_found;
        o_cmd_ready = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_idx[AW-1:0];
        w_wkey      = r_key;
        w_wref      = r_ref;
        w_re        = 1'b0;
        w_raddr     = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_key   = i_cmd.key[KEY_WIDTH-1:0];
                    n_ref   = i_cmd.entry_ref;
                    n_found = '0;
                    case (i_cmd.kind)
                        KIND_INSERT: begin
                            if (r_count == DEPTH_C) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS;
                            end
                        end
                        KIND_REMOVE: begin
                            n_idx   = '0;
                            n_state = S_REM_RD;
                        end
                        KIND_FIND: begin
                            n_lo    = '0;
                            n_hi1   = r_count;
                            n_state = S_FND_RD;
                        end
                        KIND_DONE_OK: begin
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_INS: begin
                if (r_idx == '0) begin
                    w_we     = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_idx_dec[AW-1:0];
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                w_we = 1'b1;
                if (r_rd_key > r_key) begin
                    w_wkey  = r_rd_key;
                    w_wref  = r_rd_ref;
                    n_idx   = w_idx_dec;
                    n_state = S_INS;
                end else begin
                    n_count  = r_count + CW'(1);
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_REM_RD: begin
                if (r_idx >= r_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    n_state = S_REM_CMP;
                end
            end
            S_REM_CMP: begin
                if (r_rd_ref == r_ref) begin
                    n_state = S_SH_RD;
                end else begin
                    n_idx   = w_idx_inc;
                    n_state = S_REM_RD;
                end
            end
            S_SH_RD: begin
                if (w_idx_inc >= r_count) begin
                    n_count  = r_count - CW'(1);
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_idx_inc[AW-1:0];
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                w_we    = 1'b1;
                w_wkey  = r_rd_key;
                w_wref  = r_rd_ref;
                n_idx   = w_idx_inc;
                n_state = S_SH_RD;
            end
            S_FND_RD: begin
                if (r_lo >= r_hi1) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_mid[AW-1:0];
                    n_idx   = w_mid;
                    n_state = S_FND_CMP;
                end
            end
            S_FND_CMP: begin
                if (r_rd_key < r_key) begin
                    n_lo    = w_idx_inc;
                    n_state = S_FND_RD;
                end else if (r_rd_key > r_key) begin
                    n_hi1   = r_idx;
                    n_state = S_FND_RD;
                end else begin
                    n_found  = r_rd_ref;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_key[w_waddr] <= w_wkey;
            mem_ref[w_waddr] <= w_wref;
        end
        if (w_re) begin
            r_rd_key <= mem_key[w_raddr];
            r_rd_ref <= mem_ref[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_lo     <= n_lo;
        r_hi1    <= n_hi1;
        r_key    <= n_key;
        r_ref    <= n_ref;
        r_status <= n_status;
        r_found  <= n_found;
        if (w_load) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_count  <= w_count_ext[COUNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_ref   = r_out_found;
    assign o_entry_count = r_out_count;

endmodule

`default_nettype wire

/* rtl/sorted_handle_table_top.sv */
// ============================================================================
// sorted_handle_table_top: sorted handle table with binary search lookup
// A table of up to DEPTH key and reference pairs kept in ascending key order,
// supporting insert, remove by reference and find by key.
// ============================================================================
//
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_op, i_key, i_entry_ref
// output    out        o_out_valid / i_out_ready  o_status, o_found_ref,
//                                                 o_entry_count
//
// One transaction at a time runs on a sequencer over a single-port memory.
// Insert moves each larger entry up one place; remove scans by reference and
// then shifts the later entries down; find takes at most floor(log2(count)) + 1
// probes. Refused, null and unused codes go straight to the result.
// A waiting result holds the engine; the two-entry queue takes two more meanwhile.
// Reset clears the count, the sequencer state, the result valid flag and the
// queue pointers; the memories need no clearing.
// ============================================================================
`default_nettype none

module sorted_handle_table_top
    import sht_pkg::*;
#(
    parameter int unsigned DEPTH     = 16,
    parameter int unsigned KEY_WIDTH = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [OP_WIDTH-1:0]    i_op,
    input  wire logic [FIELD_WIDTH-1:0] i_key,
    input  wire logic [FIELD_WIDTH-1:0] i_entry_ref,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [ST_WIDTH-1:0]         o_status,
    output logic [FIELD_WIDTH-1:0]      o_found_ref,
    output logic [COUNT_OUT_W-1:0]      o_entry_count
);

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;

    sht_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_entry_ref (i_entry_ref),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    sht_engine #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_ready   (w_cmd_ready),
        .i_cmd         (w_cmd),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_ref   (o_found_ref),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

/* rtl/sht_checker.sv */
// ============================================================================
// sht_checker: port-level checks of the sorted handle table
// Watches the top-level ports and flags results that cannot occur.
// ============================================================================
`default_nettype none

module sht_checker
    import sht_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [ST_WIDTH-1:0]    o_status,
    input wire logic [FIELD_WIDTH-1:0] o_found_ref,
    input wire logic [COUNT_OUT_W-1:0] o_entry_count
);

    localparam logic [COUNT_OUT_W-1:0] DEPTH_OUT = COUNT_OUT_W'(DEPTH);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_found_ref) && $stable(o_entry_count))
        else $error("Result transaction changed while stalled.");

    a_ref_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_found_ref == '0)
        else $error("Reference reported without a successful find.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_entry_count == DEPTH_OUT)
        else $error("Table full reported with a count below capacity.");

    a_hit_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK && o_found_ref != '0
            |-> o_entry_count != '0 || DEPTH_OUT == '0)
        else $error("Entry found in an empty table.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result transaction offered straight after reset.");

endmodule

bind sorted_handle_table_top sht_checker #(
    .DEPTH (DEPTH)
) u_sht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_found_ref   (o_found_ref),
    .o_entry_count (o_entry_count)
);

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking testbench for the sorted handle table
// A directed run covers the empty, null, full and equal-key cases; a long
// random run then alternates between filling and draining the table while a
// scoreboard predicts every result and compares it field by field.
// ============================================================================

module tb;
    import sht_pkg::*;

    localparam int unsigned TABLE_DEPTH  = 16;
    localparam int unsigned KEY_BITS     = 64;
    localparam int unsigned RANDOM_ITEMS = 1425;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned PACE_SPAN    = 32;

    localparam logic [OP_WIDTH-1:0]    OP_UNUSED = 2'd3;
    localparam logic [FIELD_WIDTH-1:0] ALL_ONES  = {FIELD_WIDTH{1'b1}};
    localparam logic [FIELD_WIDTH-1:0] KEY_MASK  = ALL_ONES >> (FIELD_WIDTH - KEY_BITS);
    localparam logic [FIELD_WIDTH-1:0] TOP_BIT   = 64'h8000_0000_0000_0000;

    typedef enum int {PACE_STEADY, PACE_RANDOM, PACE_SHORT} t_pace;

    typedef struct packed {
        logic [ST_WIDTH-1:0]    status;
        logic [FIELD_WIDTH-1:0] found_ref;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_reply;

    class sorted_table_scoreboard;
        logic [FIELD_WIDTH-1:0] model_keys [TABLE_DEPTH];
        logic [FIELD_WIDTH-1:0] model_refs [TABLE_DEPTH];
        int unsigned            model_count;
        t_reply                 replies_due [$];
        int unsigned            errors;

        function new();
            model_count = 0;
            errors      = 0;
        endfunction

        function void note_request(input logic [OP_WIDTH-1:0]    op,
                                   input logic [FIELD_WIDTH-1:0] key,
                                   input logic [FIELD_WIDTH-1:0] entry_ref);
            t_reply                 want;
            logic [FIELD_WIDTH-1:0] k;
            int                     pos;
            int                     hit;
            int                     low;
            int                     high;
            int                     mid;
            bit                     done;
            k                = key & KEY_MASK;
            want.status      = ST_NOT_FOUND;
            want.found_ref   = '0;
            case (op)
                OP_INSERT: begin
                    if (entry_ref == '0) begin
                        want.status = ST_OK;
                    end else if (model_count >= TABLE_DEPTH) begin
                        want.status = ST_FULL;
                    end else begin
                        pos = model_count;
                        while (pos > 0 && model_keys[pos-1] > k) begin
                            model_keys[pos] = model_keys[pos-1];
                            model_refs[pos] = model_refs[pos-1];
                            pos--;
                        end
                        model_keys[pos] = k;
                        model_refs[pos] = entry_ref;
                        model_count++;
                        want.status = ST_OK;
                    end
                end
                OP_REMOVE: begin
                    hit = -1;
                    if (entry_ref != '0) begin
                        for (pos = 0; pos < model_count && hit < 0; pos++) begin
                            if (model_refs[pos] == entry_ref) begin
                                hit = pos;
                            end
                        end
                    end
                    if (hit >= 0) begin
                        for (pos = hit; pos + 1 < model_count; pos++) begin
                            model_keys[pos] = model_keys[pos+1];
                            model_refs[pos] = model_refs[pos+1];
                        end
                        model_count--;
                        want.status = ST_OK;
                    end
                end
                OP_FIND: begin
                    low  = 0;
                    high = int'(model_count) - 1;
                    done = 1'b0;
                    while (!done && low <= high) begin
                        mid = (low + high) / 2;
                        if (model_keys[mid] < k) begin
                            low = mid + 1;
                        end else if (model_keys[mid] > k) begin
                            high = mid - 1;
                        end else begin
                            want.status    = ST_OK;
                            want.found_ref = model_refs[mid];
                            done           = 1'b1;
                        end
                    end
                end
                default: begin
                    want.status = ST_NOT_FOUND;
                end
            endcase
            want.entry_count = COUNT_OUT_W'(model_count);
            replies_due.push_back(want);
        endfunction

        function void check_reply(input logic [ST_WIDTH-1:0]    status,
                                  input logic [FIELD_WIDTH-1:0] found_ref,
                                  input logic [COUNT_OUT_W-1:0] entry_count);
            t_reply want;
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result, status %0d found_ref %h count %0d",
                         $time, status, found_ref, entry_count);
                errors++;
            end else begin
                want = replies_due.pop_front();
                if (status !== want.status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, status);
                    errors++;
                end
                if (found_ref !== want.found_ref) begin
                    $display("%0t: found_ref expected %h, actual %h",
                             $time, want.found_ref, found_ref);
                    errors++;
                end
                if (entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d, actual %0d",
                             $time, want.entry_count, entry_count);
                    errors++;
                end
            end
        endfunction

        function int unsigned outstanding();
            return replies_due.size();
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic [OP_WIDTH-1:0]    i_op        = OP_INSERT;
    logic [FIELD_WIDTH-1:0] i_key       = '0;
    logic [FIELD_WIDTH-1:0] i_entry_ref = '0;
    logic                   i_out_ready = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [ST_WIDTH-1:0]    o_status;
    logic [FIELD_WIDTH-1:0] o_found_ref;
    logic [COUNT_OUT_W-1:0] o_entry_count;

    sorted_table_scoreboard sb;
    t_pace                  send_pace;
    int unsigned            send_left = 0;
    int unsigned            idle_cycles = 0;

    sorted_handle_table_top #(
        .DEPTH     (TABLE_DEPTH),
        .KEY_WIDTH (KEY_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_entry_ref   (i_entry_ref),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_ref   (o_found_ref),
        .o_entry_count (o_entry_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_wait(input t_pace pace);
        case (pace)
            PACE_STEADY: return 0;
            PACE_RANDOM: return $urandom_range(0, 17);
            default:     return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] held_key();
        return sb.model_keys[$urandom_range(0, sb.model_count - 1)];
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] held_ref();
        return sb.model_refs[$urandom_range(0, sb.model_count - 1)];
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll <= 2 && sb.model_count > 0) begin
            return held_key();
        end else if (roll <= 5) begin
            return FIELD_WIDTH'($urandom_range(0, 7));
        end else if (roll == 6) begin
            return ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
        end
        return rand64();
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] pick_insert_ref();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            return '0;
        end else if (roll == 1 && sb.model_count > 0) begin
            return held_ref();
        end
        return rand64();
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] pick_remove_ref();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll <= 1) begin
            return '0;
        end else if (roll >= 5 && sb.model_count > 0) begin
            return held_ref();
        end
        return rand64();
    endfunction

    task automatic send_item(input logic [OP_WIDTH-1:0]    op,
                             input logic [FIELD_WIDTH-1:0] key,
                             input logic [FIELD_WIDTH-1:0] entry_ref);
        int unsigned gap;
        if (send_left == 0) begin
            send_pace = t_pace'($urandom_range(0, 2));
            send_left = PACE_SPAN;
        end
        send_left--;
        gap = draw_wait(send_pace);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_op        <= op;
        i_key       <= key;
        i_entry_ref <= entry_ref;
        i_in_valid  <= 1'b1;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        sb.note_request(op, key, entry_ref);
    endtask

    initial begin
        t_pace       recv_pace;
        int unsigned recv_left;
        int unsigned stall;
        recv_left = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (recv_left == 0) begin
                recv_pace = t_pace'($urandom_range(0, 2));
                recv_left = PACE_SPAN;
            end
            recv_left--;
            stall = draw_wait(recv_pace);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            sb.check_reply(o_status, o_found_ref, o_entry_count);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned n;
        int unsigned roll;
        bit          filling;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_FIND, '0, '0);
        send_item(OP_REMOVE, '0, 64'd1);
        send_item(OP_UNUSED, ALL_ONES, ALL_ONES);
        send_item(OP_INSERT, 64'd5, '0);
        send_item(OP_INSERT, ALL_ONES, ALL_ONES);
        // A key below every held key walks the search off the bottom of the table.
        send_item(OP_FIND, '0, '0);
        send_item(OP_INSERT, '0, 64'd1);
        send_item(OP_INSERT, TOP_BIT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(OP_INSERT, TOP_BIT, 64'h5555_5555_5555_5555);
        send_item(OP_FIND, TOP_BIT, '0);
        send_item(OP_FIND, 64'd3, '0);
        send_item(OP_REMOVE, '0, '0);
        send_item(OP_REMOVE, '0, ALL_ONES);
        for (n = 0; n < 13; n++) begin
            send_item(OP_INSERT, FIELD_WIDTH'(100 - n), FIELD_WIDTH'(n + 2));
        end
        send_item(OP_INSERT, 64'd50, 64'd77);

        filling = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (sb.model_count == 0) begin
                filling = 1'b1;
            end else if (sb.model_count == TABLE_DEPTH && $urandom_range(0, 3) == 0) begin
                filling = 1'b0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                send_item(OP_UNUSED, rand64(), rand64());
            end else if (roll < (filling ? 55 : 22)) begin
                send_item(OP_INSERT, pick_key(), pick_insert_ref());
            end else if (roll < 75) begin
                send_item(OP_REMOVE, rand64(), pick_remove_ref());
            end else if (sb.model_count > 0 && $urandom_range(0, 1) != 0) begin
                send_item(OP_FIND, held_key(), rand64());
            end else begin
                send_item(OP_FIND, pick_key(), rand64());
            end
        end
        i_in_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/sht_pkg.sv
rtl/sht_front.sv
rtl/sht_engine.sv
rtl/sorted_handle_table_top.sv
rtl/sht_checker.sv
verif/tb.sv
